// ----- rtl/core/aitf_pkg.sv -----
// Shared types and constants for the aging id-to-feature table.
`default_nettype none
package aitf_pkg;

	localparam int unsigned AGENT_ID_W = 16;
	localparam int unsigned FEATURE_W  = 8;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned COUNT_W    = 7;

	localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd1000;

	localparam logic MODE_LEARN = 1'b0;
	localparam logic MODE_SWEEP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_STALE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SWEEP    = 3'd4;

	typedef struct packed {
		logic                  mode;
		logic [AGENT_ID_W-1:0] agent_id;
		logic [FEATURE_W-1:0]  feature_code;
		logic [TIME_W-1:0]     time_value;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  removed_count;
		logic [COUNT_W-1:0]  entries_used;
	} out_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/aging_id_to_feature_table.sv -----
// Top level of the aging id-to-feature table: config register, sequencer, RAM, result register.
// Each item walks every table slot through the single read port of the record RAM, one slot
// per cycle, then takes a write-back step (S_FINISH) and a result hand-over step (S_RESP)
// that waits while the result register is stalled; no new item is taken until the sequencer
// is back in idle. The record RAM is only written after a scan ends and only read during a
// scan, so lookups never see a write in flight. Slot valid bits live in flip-flops and clear
// at reset; the RAM itself needs no clearing. max_age may be written only while no item is
// in flight; a write is always taken.
`default_nettype none
module aging_id_to_feature_table #(
	parameter int unsigned TABLE_ENTRIES = 64,
	parameter int unsigned FEATURE_BITS  = 8,
	parameter int unsigned ID_BITS       = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire aitf_pkg::in_item_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output aitf_pkg::out_item_t                out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [aitf_pkg::TIME_W-1:0]   cfg_data
);

	import aitf_pkg::*;

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned DW = ID_BITS + FEATURE_BITS + TIME_W;

	logic [TIME_W-1:0] max_age_q;
	logic              res_valid;
	logic              res_ready;
	out_item_t         res;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DW-1:0]     ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DW-1:0]     ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= MAX_AGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_age_q <= cfg_data;
		end
	end

	aitf_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.FEATURE_BITS  (FEATURE_BITS),
		.ID_BITS       (ID_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.max_age   (max_age_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	aitf_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// hold the result until the downstream transfer completes
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/aitf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module aitf_ram #(
	parameter int unsigned WIDTH = 56,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/aitf_ctrl.sv -----
// Scan sequencer: lookup, insert, update and aging sweep over the record RAM.
`default_nettype none
module aitf_ctrl #(
	parameter int unsigned TABLE_ENTRIES = 64,
	parameter int unsigned FEATURE_BITS  = 8,
	parameter int unsigned ID_BITS       = 16
) (
	input  wire logic                                                       clk,
	input  wire logic                                                       arst_n,
	input  wire logic                                                       in_valid,
	output logic                                                            in_stall,
	input  wire aitf_pkg::in_item_t                                         in_data,
	input  wire logic [aitf_pkg::TIME_W-1:0]                                max_age,
	output logic                                                            res_valid,
	input  wire logic                                                       res_ready,
	output aitf_pkg::out_item_t                                             res,
	output logic                                                            ram_we,
	output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0]      ram_waddr,
	output logic [ID_BITS+FEATURE_BITS+aitf_pkg::TIME_W-1:0]                ram_wdata,
	output logic                                                            ram_re,
	output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0]      ram_raddr,
	input  wire logic [ID_BITS+FEATURE_BITS+aitf_pkg::TIME_W-1:0]           ram_rdata
);

	import aitf_pkg::*;

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned DW = ID_BITS + FEATURE_BITS + TIME_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_FINISH = 4'b0100,
		S_RESP   = 4'b1000
	} state_t;

	state_t                    state_q;
	logic                      issue_q;
	logic [AW-1:0]             addr_q;
	logic                      rd_v_s1;
	logic [AW-1:0]             addr_s1;
	logic                      mode_q;
	logic [ID_BITS-1:0]        id_q;
	logic [FEATURE_BITS-1:0]   feat_q;
	logic [TIME_W-1:0]         time_q;
	logic                      sweep_en_q;
	logic [TIME_W-1:0]         limit_q;
	logic                      hit_q;
	logic [AW-1:0]             hit_idx_q;
	logic                      newer_q;
	logic                      free_q;
	logic [AW-1:0]             free_idx_q;
	logic [CW-1:0]             removed_q;
	logic [CW-1:0]             used_q;
	logic [TABLE_ENTRIES-1:0]  valid_q;

	logic                      accept;
	logic [ID_BITS-1:0]        rd_id;
	logic [TIME_W-1:0]         rd_time;
	logic                      rd_learn_hit;
	logic                      rd_learn_free;
	logic                      rd_remove;
	logic [STATUS_W-1:0]       status;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign rd_id   = ram_rdata[DW-1 -: ID_BITS];
	assign rd_time = ram_rdata[TIME_W-1:0];

	assign rd_learn_hit  = rd_v_s1 && (mode_q == MODE_LEARN) && valid_q[addr_s1]
		&& !hit_q && (rd_id == id_q);
	assign rd_learn_free = rd_v_s1 && (mode_q == MODE_LEARN) && !valid_q[addr_s1] && !free_q;
	assign rd_remove     = rd_v_s1 && (mode_q == MODE_SWEEP) && sweep_en_q
		&& valid_q[addr_s1] && (rd_time < limit_q);

	assign ram_re    = (state_q == S_SCAN) && issue_q;
	assign ram_raddr = addr_q;
	assign ram_we    = (state_q == S_FINISH) && (mode_q == MODE_LEARN)
		&& (hit_q ? newer_q : free_q);
	assign ram_waddr = hit_q ? hit_idx_q : free_idx_q;
	assign ram_wdata = {id_q, feat_q, time_q};

	always_comb begin
		priority if (mode_q == MODE_SWEEP) begin
			status = ST_SWEEP;
		end else if (hit_q) begin
			status = newer_q ? ST_UPDATED : ST_STALE;
		end else if (free_q) begin
			status = ST_INSERTED;
		end else begin
			status = ST_FULL;
		end
	end

	assign res_valid         = (state_q == S_RESP);
	assign res.status        = status;
	assign res.removed_count = COUNT_W'(removed_q);
	assign res.entries_used  = COUNT_W'(used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			issue_q   <= 1'b0;
			rd_v_s1   <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
			used_q    <= '0;
			valid_q   <= '0;
		end else begin
			rd_v_s1 <= ram_re;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q   <= S_SCAN;
						issue_q   <= 1'b1;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						removed_q <= '0;
					end
				end
				S_SCAN: begin
					if (issue_q && (addr_q == LAST_ADDR)) begin
						issue_q <= 1'b0;
					end
					if (rd_learn_hit) begin
						hit_q <= 1'b1;
					end
					if (rd_learn_free) begin
						free_q <= 1'b1;
					end
					if (rd_remove) begin
						valid_q[addr_s1] <= 1'b0;
						removed_q        <= removed_q + 1'b1;
						used_q           <= used_q - 1'b1;
					end
					if (rd_v_s1 && (addr_s1 == LAST_ADDR)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if ((mode_q == MODE_LEARN) && !hit_q && free_q) begin
						valid_q[free_idx_q] <= 1'b1;
						used_q              <= used_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if (accept) begin
			addr_q     <= '0;
			mode_q     <= in_data.mode;
			id_q       <= ID_BITS'(in_data.agent_id);
			feat_q     <= FEATURE_BITS'(in_data.feature_code);
			time_q     <= in_data.time_value;
			sweep_en_q <= (in_data.time_value >= max_age);
			limit_q    <= in_data.time_value - max_age;
		end else if (ram_re) begin
			addr_q <= addr_q + 1'b1;
		end
		if (rd_learn_hit) begin
			hit_idx_q <= addr_s1;
			newer_q   <= (time_q > rd_time);
		end
		if (rd_learn_free) begin
			free_idx_q <= addr_s1;
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TABLE_ENTRIES))
		else $error("record count exceeds table size");

	a_write_in_finish: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_FINISH) && (mode_q == MODE_LEARN))
		else $error("record write outside the finish step");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == S_SCAN))
		else $error("read data returned outside the scan");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN) && issue_q && (removed_q == '0))
		else $error("accepted item did not start a scan");

	a_remove_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rd_remove |=> (used_q == $past(used_q) - 1'b1))
		else $error("removal did not lower the record count");

endmodule
`default_nettype wire
